// ----- src/multi_source_staleness_monitor_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Staleness monitor assertion macros
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_SOURCE_STALENESS_MONITOR_UNIT_ASSERT_SVH
`define MULTI_SOURCE_STALENESS_MONITOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MSM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("staleness monitor assertion failed");
`define MSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("staleness monitor assertion failed");
`else
`define MSM_ASSERT_SAME(label, ante, cons)
`define MSM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/msm_pkg.sv -----
// ----------------------------------------------------------------------------
// Staleness monitor package
// Shared constants, types and the age classification function.
// ----------------------------------------------------------------------------
package msm_pkg;

  localparam logic [1:0] CLS_FRESH   = 2'd0;
  localparam logic [1:0] CLS_AGING   = 2'd1;
  localparam logic [1:0] CLS_STALE   = 2'd2;
  localparam logic [1:0] CLS_UNKNOWN = 2'd3;

  localparam logic REG_AGING = 1'b0;
  localparam logic REG_STALE = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

  function automatic logic [1:0] class_of_age(input logic [31:0] age,
                                              input logic [31:0] aging_thr,
                                              input logic [31:0] stale_thr);
    logic [1:0] cls;
    if (age >= stale_thr) begin
      cls = CLS_STALE;
    end else if (age >= aging_thr) begin
      cls = CLS_AGING;
    end else begin
      cls = CLS_FRESH;
    end
    return cls;
  endfunction

endpackage

// ----- src/msm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Staleness monitor controller
// Sequences acceptance, the source scan and the result load.
// ----------------------------------------------------------------------------
module msm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  msm_pkg::status_t status,
  output msm_pkg::cmd_t    cmd
);

  msm_pkg::state_t state_r;
  msm_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      msm_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = msm_pkg::S_SCAN;
        end
      end
      msm_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = msm_pkg::S_FINISH;
        end
      end
      msm_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.load  = 1'b1;
          in_tready = 1'b1;
          if (in_tvalid) begin
            cmd.start = 1'b1;
            state_nxt = msm_pkg::S_SCAN;
          end else begin
            state_nxt = msm_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = msm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/msm_datapath.sv -----
// ----------------------------------------------------------------------------
// Staleness monitor datapath
// Clock, per-source update times, scan accumulators and the output register.
// ----------------------------------------------------------------------------
module msm_datapath #(
  parameter int NUM_SOURCES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  msm_pkg::cmd_t                  cmd,
  output msm_pkg::status_t               status,
  input  logic [msm_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [31:0]                    aging_thr,
  input  logic [31:0]                    stale_thr,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [msm_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [15:0] elapsed;
  logic        upd_en;
  logic [2:0]  upd_src;
  logic [2:0]  qry_src;

  logic [31:0]      clock_r;
  logic [31:0]      clock_nxt;
  logic [31:0]      last_r [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] seen_r;
  logic [2:0]       qry_src_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;

  logic       any_seen_r;
  logic       any_st_r;
  logic       all_fr_r;
  logic [1:0] worst_r;
  logic [1:0] q_class_r;
  logic [31:0] q_age_r;

  logic [31:0] age;
  logic [1:0]  cls;
  logic        cur_seen;
  logic        hit;
  logic        scan_last;

  logic        out_valid_r;
  logic [1:0]  o_q_class_r;
  logic [31:0] o_q_age_r;
  logic        o_any_st_r;
  logic        o_all_fr_r;
  logic [1:0]  o_overall_r;

  assign elapsed = in_tdata[15:0];
  assign upd_en  = in_tdata[16];
  assign upd_src = in_tdata[19:17];
  assign qry_src = in_tdata[22:20];

  assign clock_nxt = clock_r + 32'(elapsed);
  assign scan_last = (32'(idx_r) == 32'(NUM_SOURCES - 1));
  assign idx_nxt   = scan_last ? idx_r : idx_r + IDX_W'(1);
  assign age       = clock_r - last_r[idx_r];
  assign cls       = msm_pkg::class_of_age(age, aging_thr, stale_thr);
  assign cur_seen  = seen_r[idx_r];
  assign hit       = (32'(idx_r) == 32'(qry_src_r));

  assign status.scan_last = scan_last;
  assign status.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r     <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        clock_r <= clock_nxt;
        for (int i = 0; i < NUM_SOURCES; i++) begin
          if (upd_en && (32'(upd_src) == i)) begin
            seen_r[i] <= 1'b1;
          end
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (upd_en && (32'(upd_src) == i)) begin
          last_r[i] <= clock_nxt;
        end
      end
      qry_src_r  <= qry_src;
      idx_r      <= '0;
      any_seen_r <= 1'b0;
      any_st_r   <= 1'b0;
      all_fr_r   <= 1'b1;
      worst_r    <= msm_pkg::CLS_FRESH;
      q_class_r  <= msm_pkg::CLS_UNKNOWN;
      q_age_r    <= '1;
    end else if (cmd.scan) begin
      idx_r <= idx_nxt;
      if (cur_seen) begin
        any_seen_r <= 1'b1;
        if (cls == msm_pkg::CLS_STALE) begin
          any_st_r <= 1'b1;
        end
        if (cls != msm_pkg::CLS_FRESH) begin
          all_fr_r <= 1'b0;
        end
        if (cls > worst_r) begin
          worst_r <= cls;
        end
        if (hit) begin
          q_class_r <= cls;
          q_age_r   <= age;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      o_q_class_r <= q_class_r;
      o_q_age_r   <= q_age_r;
      o_any_st_r  <= any_st_r;
      o_all_fr_r  <= all_fr_r;
      o_overall_r <= any_seen_r ? worst_r : msm_pkg::CLS_UNKNOWN;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, o_overall_r, o_all_fr_r, o_any_st_r, o_q_age_r, o_q_class_r};

endmodule

// ----- src/multi_source_staleness_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-source staleness monitor
// Tracks a millisecond clock and the last update time of each data source.
// ----------------------------------------------------------------------------
// Each input transaction advances the clock by elapsed_ms, optionally marks
// one source updated at the new time, and produces one result transaction
// with the queried source's age and class plus a summary over seen sources.
// The datapath reads one stored update time per cycle: after acceptance, the
// scan state steps through the sources in turn, then the finish state loads
// the output register, which drives out_tvalid, once that register is free.
// With a ready receiver the next transaction is taken in that loading cycle,
// and none is taken during the scan. The user must write thresholds through
// the APB port while no transaction is open; the block does not enforce it.
// Reset clears the clock to zero and marks every source unseen; thresholds
// return to 1000 and 5000. If the receiver stalls, the result waits in the
// output register while the next transaction is scanned, and the block holds
// in_tready low once a second result is ready to load.
// ----------------------------------------------------------------------------
`include "multi_source_staleness_monitor_unit_assert.svh"

module multi_source_staleness_monitor_unit #(
  parameter int NUM_SOURCES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // elapsed_ms[15:0], update_enable[16], update_source[19:17],
  // query_source[22:20], zero[23]
  input  logic [msm_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // query_class[1:0], query_age[33:2], any_stale[34], all_fresh[35],
  // overall_class[37:36], zero[39:38]
  output logic [msm_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [2:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  logic [31:0] aging_thr_r;
  logic [31:0] stale_thr_r;
  logic        cfg_wr;

  logic        rpt_none_seen;
  logic        rpt_query_stale;
  logic        rpt_calm;
  logic        rpt_alarm;

  msm_pkg::cmd_t    cmd;
  msm_pkg::status_t status;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_thr_r <= 32'd1000;
      stale_thr_r <= 32'd5000;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        msm_pkg::REG_AGING: aging_thr_r <= cfg_pwdata;
        msm_pkg::REG_STALE: stale_thr_r <= cfg_pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      msm_pkg::REG_AGING: cfg_prdata = aging_thr_r;
      msm_pkg::REG_STALE: cfg_prdata = stale_thr_r;
      default:            cfg_prdata = '0;
    endcase
  end

  msm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  msm_datapath #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .aging_thr  (aging_thr_r),
    .stale_thr  (stale_thr_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign rpt_none_seen   = out_tvalid && (out_tdata[37:36] == msm_pkg::CLS_UNKNOWN);
  assign rpt_query_stale = out_tvalid && (out_tdata[1:0] == msm_pkg::CLS_STALE);
  assign rpt_calm        = !out_tdata[34] && out_tdata[35];
  assign rpt_alarm       = out_tdata[34] && !out_tdata[35];

  `MSM_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `MSM_ASSERT_NEXT(a_load_shows_result, cmd.load, out_tvalid)
  `MSM_ASSERT_SAME(a_none_seen_summary, rpt_none_seen, rpt_calm)
  `MSM_ASSERT_SAME(a_query_stale_flags, rpt_query_stale, rpt_alarm)

endmodule
